// File: src/frame_rate_meter_limiter_unit_macros.svh
// Assertion macros for the frame rate meter checker.
// Self-contained; included by the checker file only.
`ifndef FRAME_RATE_METER_LIMITER_UNIT_MACROS_SVH
`define FRAME_RATE_METER_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FRML_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("frml check failed");

// Next-cycle implication, disabled during reset.
`define FRML_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("frml check failed");

`endif

// File: src/frml_pkg.sv
// Shared types, constants and microcode ROM for the frame rate meter.
// No dependencies.
package frml_pkg;

	localparam int FRAME_W = 16;
	localparam int FPS_W = 22;
	localparam int DELAY_W = 10;
	localparam int RATE_SCALE = 256000;
	localparam int BUDGET_NUM = 1000;
	localparam logic [DELAY_W-1:0] MAX_FPS_RESET = 10'd60;
	localparam logic [FPS_W-1:0] FPS_DEFAULT_Q8 = 22'd15360;
	localparam logic [FPS_W-1:0] FPS_MAX = '1;

	// event word kinds
	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef logic [3:0] upc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_PREP,
		OP_RETIRE,
		OP_INSERT,
		OP_DIV_RATE,
		OP_DIV_STEP,
		OP_SET_RATE,
		OP_DIV_BUDGET,
		OP_SET_DELAY,
		OP_PUBLISH
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_END,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} ctl_t;

	localparam upc_t UPC_IDLE      = 4'd0;
	localparam upc_t UPC_PREP      = 4'd1;
	localparam upc_t UPC_RETIRE    = 4'd2;
	localparam upc_t UPC_INSERT    = 4'd3;
	localparam upc_t UPC_DIV_RATE  = 4'd4;
	localparam upc_t UPC_RATE_LOOP = 4'd5;
	localparam upc_t UPC_SET_RATE  = 4'd6;
	localparam upc_t UPC_DIV_BUD   = 4'd7;
	localparam upc_t UPC_BUD_LOOP  = 4'd8;
	localparam upc_t UPC_SET_DELAY = 4'd9;
	localparam upc_t UPC_PUBLISH   = 4'd10;
	localparam upc_t UPC_RETURN    = 4'd11;

	// One control word per step; a true condition jumps to target,
	// otherwise the step counter advances.
	function automatic ctl_t ucode_rom(upc_t addr);
		ctl_t w;
		case (addr)
			UPC_IDLE:      w = '{OP_ACCEPT,     C_NO_END,   UPC_IDLE};
			UPC_PREP:      w = '{OP_PREP,       C_NONE,     UPC_IDLE};
			UPC_RETIRE:    w = '{OP_RETIRE,     C_NONE,     UPC_IDLE};
			UPC_INSERT:    w = '{OP_INSERT,     C_NONE,     UPC_IDLE};
			UPC_DIV_RATE:  w = '{OP_DIV_RATE,   C_NONE,     UPC_IDLE};
			UPC_RATE_LOOP: w = '{OP_DIV_STEP,   C_DIV_MORE, UPC_RATE_LOOP};
			UPC_SET_RATE:  w = '{OP_SET_RATE,   C_NONE,     UPC_IDLE};
			UPC_DIV_BUD:   w = '{OP_DIV_BUDGET, C_NONE,     UPC_IDLE};
			UPC_BUD_LOOP:  w = '{OP_DIV_STEP,   C_DIV_MORE, UPC_BUD_LOOP};
			UPC_SET_DELAY: w = '{OP_SET_DELAY,  C_NONE,     UPC_IDLE};
			UPC_PUBLISH:   w = '{OP_PUBLISH,    C_OUT_BUSY, UPC_PUBLISH};
			UPC_RETURN:    w = '{OP_NOP,        C_ALWAYS,   UPC_IDLE};
			default:       w = '{OP_NOP,        C_ALWAYS,   UPC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: src/frml_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module frml_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/frame_rate_meter_limiter_unit.sv
// Frame begin word: taken in the idle step, no result. Frame end word: result
// valid after the prepare, retire, insert, rate divide, budget divide, delay and
// publish steps (NUM_W = 22 bits of 256000*WINDOW); no new word is taken until
// the result is published, which waits while the output register is full. The
// shared bit-serial divider is run once for the rate and once for the frame
// budget. arst_n clears control state, the running sum and max_fps (to 60); ring
// contents stay undefined until written. Top level of the frame rate meter and
// limiter. Depends on frml_pkg and frml_ram.
module frame_rate_meter_limiter_unit #(
	parameter int WINDOW = 10,
	parameter int INTERVAL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// event words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] timestamp_ms,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] frame_ms,
	output logic [21:0] fps_q8,
	output logic [9:0]  delay_ms,
	// max_fps register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = INTERVAL_BITS + $clog2(WINDOW);
	localparam int DIV_W  = (SUM_W > frml_pkg::DELAY_W) ? SUM_W : frml_pkg::DELAY_W;
	localparam int NUM_W  = $clog2(frml_pkg::RATE_SCALE * WINDOW + 1);
	localparam int QW     = (NUM_W > frml_pkg::FPS_W) ? NUM_W : frml_pkg::FPS_W;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam logic [32:0] LIMIT = (33'd1 << INTERVAL_BITS) - 33'd1;

	// sequencer
	frml_pkg::upc_t upc_q, upc_d;
	frml_pkg::ctl_t ctl;
	logic           cond_true;

	// state
	logic [9:0]               max_fps_q;
	logic [31:0]              begin_q;
	logic [31:0]              ts_q;
	logic [31:0]              last_end_q;
	logic                     seen_end_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [CNT_W-1:0]         filled_q;
	logic [SUM_W-1:0]         sum_q;
	logic [INTERVAL_BITS-1:0] ivl_q;
	logic [15:0]              frame_q;
	logic [21:0]              fps_res_q;
	logic [9:0]               delay_res_q;

	// divider
	logic [NUM_W-1:0]  num_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsor_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIV_W:0]    rem_sh;
	logic              rem_ge;
	logic [DIV_W:0]    rem_sub;

	// output register
	logic        out_valid_q;
	logic [15:0] frame_out_q;
	logic [21:0] fps_out_q;
	logic [9:0]  delay_out_q;

	logic                     in_fire, end_fire, out_free;
	logic [31:0]              diff;
	logic [32:0]              raw33, sat33;
	logic [INTERVAL_BITS-1:0] old_ivl;
	logic [QW-1:0]            quot_x;
	logic [21:0]              fps_val;
	logic [9:0]               budget;
	logic [31:0]              elapsed;
	logic [9:0]               delay_val;
	logic [9:0]               fps_div;

	assign ctl       = frml_pkg::ucode_rom(upc_q);
	assign in_ready  = (ctl.op == frml_pkg::OP_ACCEPT);
	assign in_fire   = in_valid & in_ready;
	assign end_fire  = in_fire & (kind == frml_pkg::KIND_END);
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		case (ctl.cond)
			frml_pkg::C_NONE:     cond_true = 1'b0;
			frml_pkg::C_ALWAYS:   cond_true = 1'b1;
			frml_pkg::C_NO_END:   cond_true = !end_fire;
			frml_pkg::C_DIV_MORE: cond_true = (dcnt_q != DCNT_W'(1));
			frml_pkg::C_OUT_BUSY: cond_true = !out_free;
			default:              cond_true = 1'b0;
		endcase
		upc_d = cond_true ? ctl.target : upc_q + 4'd1;
	end

	// Interval since previous end, zero on the first end, saturated.
	always_comb begin
		diff  = ts_q - last_end_q;
		raw33 = seen_end_q ? {1'b0, diff} : 33'd0;
		sat33 = (raw33 > LIMIT) ? LIMIT : raw33;
	end

	// One restoring divide step: quotient bits shift into num_q.
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		rem_ge  = (rem_sh >= {1'b0, dsor_q});
		rem_sub = rem_sh - {1'b0, dsor_q};
	end

	// Rate: default when the sum is zero, else clamp to the field.
	always_comb begin
		quot_x  = QW'(num_q);
		fps_val = (quot_x > QW'(frml_pkg::FPS_MAX)) ? frml_pkg::FPS_MAX
			: quot_x[21:0];
		if (sum_q == '0) begin
			fps_val = frml_pkg::FPS_DEFAULT_Q8;
		end
	end

	// Limiter delay: budget minus time since begin, floored at zero.
	always_comb begin
		budget    = num_q[9:0];
		elapsed   = ts_q - begin_q;
		delay_val = (elapsed < {22'd0, budget}) ? (budget - elapsed[9:0]) : 10'd0;
		fps_div   = (max_fps_q == 10'd0) ? 10'd1 : max_fps_q;
	end

	frml_ram #(
		.WIDTH(INTERVAL_BITS),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ctl.op == frml_pkg::OP_INSERT),
		.waddr(slot_q),
		.wdata(ivl_q),
		.raddr(slot_q),
		.rdata(old_ivl)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q      <= frml_pkg::UPC_IDLE;
			max_fps_q  <= frml_pkg::MAX_FPS_RESET;
			begin_q    <= '0;
			last_end_q <= '0;
			seen_end_q <= 1'b0;
			slot_q     <= '0;
			filled_q   <= '0;
			sum_q      <= '0;
			dcnt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (cfg_valid && cfg_ready) begin
				max_fps_q <= cfg_data;
			end
			if (in_fire && (kind == frml_pkg::KIND_BEGIN)) begin
				begin_q <= timestamp_ms;
			end
			case (ctl.op)
				frml_pkg::OP_PREP: begin
					last_end_q <= ts_q;
					seen_end_q <= 1'b1;
				end
				frml_pkg::OP_RETIRE: begin
					// ring full: the slot about to be overwritten leaves the sum
					if (filled_q == CNT_W'(WINDOW)) begin
						sum_q <= sum_q - SUM_W'(old_ivl);
					end
				end
				frml_pkg::OP_INSERT: begin
					sum_q  <= sum_q + SUM_W'(ivl_q);
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (filled_q != CNT_W'(WINDOW)) begin
						filled_q <= filled_q + 1'b1;
					end
				end
				frml_pkg::OP_DIV_RATE: begin
					dcnt_q <= DCNT_W'(NUM_W);
				end
				frml_pkg::OP_DIV_BUDGET: begin
					dcnt_q <= DCNT_W'(NUM_W);
				end
				frml_pkg::OP_DIV_STEP: begin
					dcnt_q <= dcnt_q - 1'b1;
				end
				default: begin
				end
			endcase
			if (ctl.op == frml_pkg::OP_PUBLISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (end_fire) begin
			ts_q <= timestamp_ms;
		end
		case (ctl.op)
			frml_pkg::OP_PREP: begin
				ivl_q   <= sat33[INTERVAL_BITS-1:0];
				frame_q <= sat33[15:0];
			end
			frml_pkg::OP_DIV_RATE: begin
				num_q  <= NUM_W'(frml_pkg::RATE_SCALE * int'(filled_q));
				rem_q  <= '0;
				dsor_q <= DIV_W'(sum_q);
			end
			frml_pkg::OP_DIV_BUDGET: begin
				num_q  <= NUM_W'(frml_pkg::BUDGET_NUM);
				rem_q  <= '0;
				dsor_q <= DIV_W'(fps_div);
			end
			frml_pkg::OP_DIV_STEP: begin
				rem_q <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
				num_q <= {num_q[NUM_W-2:0], rem_ge};
			end
			frml_pkg::OP_SET_RATE: begin
				fps_res_q <= fps_val;
			end
			frml_pkg::OP_SET_DELAY: begin
				delay_res_q <= delay_val;
			end
			default: begin
			end
		endcase
		if (ctl.op == frml_pkg::OP_PUBLISH && out_free) begin
			frame_out_q <= frame_q;
			fps_out_q   <= fps_res_q;
			delay_out_q <= delay_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_ms  = frame_out_q;
	assign fps_q8    = fps_out_q;
	assign delay_ms  = delay_out_q;

endmodule

// File: src/frml_checker.sv
// Port-level checks for the frame rate meter, bound to the top level.
// Depends on frml_pkg and frame_rate_meter_limiter_unit_macros.svh.
`include "frame_rate_meter_limiter_unit_macros.svh"

module frml_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] frame_ms,
	input logic [21:0] fps_q8,
	input logic [9:0]  delay_ms
);

	// stalled result word holds
	`FRML_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame_ms) && $stable(fps_q8) && $stable(delay_ms))

	// delay never exceeds the one-frame budget at 1 fps
	`FRML_ASSERT_NOW(a_delay_range, clk, arst_n, out_valid, delay_ms <= 10'(frml_pkg::BUDGET_NUM))

	// a begin word produces no result
	`FRML_ASSERT_NEXT(a_begin_silent, clk, arst_n, in_valid && in_ready && (kind == frml_pkg::KIND_BEGIN), !$rose(out_valid))

	// an end word occupies the block
	`FRML_ASSERT_NEXT(a_end_busy, clk, arst_n, in_valid && in_ready && (kind == frml_pkg::KIND_END), !in_ready)

endmodule

bind frame_rate_meter_limiter_unit frml_checker u_frml_checker (.*);
